// ----- design/sgrc_pkg.sv -----
// Package for the slash grid region counter: sizes, node and cell types,
// handshake structs between the top level and the union-find engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgrc_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int MAX_COLS   = 32;
  localparam int NODE_COUNT = MAX_ROWS * MAX_COLS * 4;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int SIZE_W     = 6;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] CH_SLASH     = 8'd47;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [1:0] {
    CLS_SLASH,
    CLS_BACK,
    CLS_OPEN
  } cell_cls_e;

  // Join slots of one cell: three inside the cell, then right, then down.
  localparam logic [2:0] SLOT_RIGHT = 3'd3;
  localparam logic [2:0] SLOT_DOWN  = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [1:0] a_off;
    logic [1:0] b_off;
  } inner_join_t;

  typedef struct packed {
    logic  start;
    logic  clear;
    node_t clr_last;
    node_t a;
    node_t b;
  } uf_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic merged;
  } uf_rsp_t;

  typedef enum logic [2:0] {
    UF_IDLE,
    UF_CLEAR,
    UF_PARENT,
    UF_GRAND
  } uf_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_ISSUE,
    T_WAIT,
    T_NEXT,
    T_FIN
  } top_state_e;

  // Triangles: 0 top, 1 right, 2 bottom, 3 left.
  function automatic inner_join_t inner_join(cell_cls_e cls, logic [2:0] slot);
    inner_join_t r;
    r = '{valid: 1'b0, a_off: 2'd0, b_off: 2'd0};
    unique case (cls)
      CLS_SLASH: begin
        if (slot == 3'd0) r = '{valid: 1'b1, a_off: 2'd0, b_off: 2'd3};
        if (slot == 3'd1) r = '{valid: 1'b1, a_off: 2'd1, b_off: 2'd2};
      end
      CLS_BACK: begin
        if (slot == 3'd0) r = '{valid: 1'b1, a_off: 2'd0, b_off: 2'd1};
        if (slot == 3'd1) r = '{valid: 1'b1, a_off: 2'd2, b_off: 2'd3};
      end
      default: begin
        if (slot == 3'd0) r = '{valid: 1'b1, a_off: 2'd0, b_off: 2'd1};
        if (slot == 3'd1) r = '{valid: 1'b1, a_off: 2'd1, b_off: 2'd2};
        if (slot == 3'd2) r = '{valid: 1'b1, a_off: 2'd2, b_off: 2'd3};
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/sgrc_ram.sv -----
// Generic single-clock RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sgrc_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 12,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/sgrc_engine.sv -----
// Union-find engine: parent table RAM, find with path halving, join, clear sweep.
// Depends on sgrc_pkg and sgrc_ram.
`timescale 1ns / 1ps
`default_nettype none
module sgrc_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sgrc_pkg::uf_req_t req_i,
  output sgrc_pkg::uf_rsp_t     rsp_o
);
  import sgrc_pkg::*;

  uf_state_e state_q, state_d;
  node_t     cur_q, cur_d;
  node_t     ra_q, ra_d;
  node_t     b_q, b_d;
  logic      phase_q, phase_d;
  node_t     clr_q, clr_d;
  node_t     clr_last_q, clr_last_d;

  logic  wr_en, rd_en;
  node_t wr_addr, wr_data, rd_addr, rd_data;
  logic  done, merged;

  sgrc_ram #(.DEPTH(NODE_COUNT), .WIDTH(NODE_W)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    if (req_i.clear) begin
      state_d = UF_CLEAR;
    end else begin
      unique case (state_q)
        UF_IDLE:   if (req_i.start) state_d = UF_PARENT;
        UF_CLEAR:  if (clr_q == clr_last_q) state_d = UF_IDLE;
        UF_PARENT: begin
          if (rd_data != cur_q) state_d = UF_GRAND;
          else if (phase_q) state_d = UF_IDLE;
        end
        UF_GRAND:  state_d = UF_PARENT;
        default:   state_d = UF_IDLE;
      endcase
    end
  end

  // Datapath and memory controls
  always_comb begin
    cur_d      = cur_q;
    ra_d       = ra_q;
    b_d        = b_q;
    phase_d    = phase_q;
    clr_d      = clr_q;
    clr_last_d = clr_last_q;
    wr_en      = 1'b0;
    wr_addr    = cur_q;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    done       = 1'b0;
    merged     = 1'b0;
    if (req_i.clear) begin
      clr_d      = '0;
      clr_last_d = req_i.clr_last;
    end else begin
      unique case (state_q)
        UF_IDLE: begin
          if (req_i.start) begin
            cur_d   = req_i.a;
            b_d     = req_i.b;
            phase_d = 1'b0;
            rd_en   = 1'b1;
            rd_addr = req_i.a;
          end
        end
        UF_CLEAR: begin
          wr_en   = 1'b1;
          wr_addr = clr_q;
          wr_data = clr_q;
          clr_d   = clr_q + 1'b1;
        end
        UF_PARENT: begin
          if (rd_data != cur_q) begin
            // not a root yet: fetch the grandparent
            rd_en   = 1'b1;
            rd_addr = rd_data;
          end else if (!phase_q) begin
            ra_d    = cur_q;
            cur_d   = b_q;
            phase_d = 1'b1;
            rd_en   = 1'b1;
            rd_addr = b_q;
          end else begin
            done = 1'b1;
            if (ra_q != cur_q) begin
              merged  = 1'b1;
              wr_en   = 1'b1;
              wr_addr = ra_q;
              wr_data = cur_q;
            end
          end
        end
        UF_GRAND: begin
          // halve the path: point cur at its grandparent and move there
          wr_en   = 1'b1;
          wr_addr = cur_q;
          wr_data = rd_data;
          cur_d   = rd_data;
          rd_en   = 1'b1;
          rd_addr = rd_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= UF_CLEAR;
      clr_q      <= '0;
      clr_last_q <= node_t'(NODE_COUNT - 1);
      phase_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_last_q <= clr_last_d;
      phase_q    <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    ra_q  <= ra_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy   = (state_q != UF_IDLE) || req_i.clear;
  assign rsp_o.done   = done && !req_i.clear;
  assign rsp_o.merged = merged;

endmodule
`default_nettype wire

// ----- design/slash_grid_region_counter.sv -----
// Slash grid region counter: top level with the cell sequencer and config.
// Depends on sgrc_pkg and sgrc_engine.
// Per cell: the sequencer accepts a character, then walks its five join slots in order,
//   skipping an invalid slot or issuing a join to the engine and waiting for it to finish.
//   A new cell is taken only when the previous one is through and the engine is idle.
// After the last cell the count is registered once the output is free, then a sweep of
//   rows*cols*4 entries restores the table before the next cell is taken.
// Reset: the size registers go to 1, then a sweep initializes all 4096 table entries; a
//   config write restarts the grid and sweeps all 4096 entries again.
`timescale 1ns / 1ps
`default_nettype none
module slash_grid_region_counter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sgrc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [sgrc_pkg::SIZE_W-1:0]        cfg_data_i,
  input  wire logic                               cell_char_valid_i,
  output logic                                    cell_char_stall_o,
  input  wire logic [7:0]                         cell_char_i,
  output logic                                    region_count_valid_o,
  input  wire logic                               region_count_stall_i,
  output logic [sgrc_pkg::COUNT_W-1:0]            region_count_o
);
  import sgrc_pkg::*;

  top_state_e state_q, state_d;
  logic [SIZE_W-1:0]  rows_cfg_q, cols_cfg_q;
  logic [SIZE_W-1:0]  rows_eff, cols_eff;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  node_t              base_q;
  logic [COUNT_W-1:0] merges_q, merges_d;
  logic [2:0]         slot_q, slot_d;
  cell_cls_e          cls_q;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q;
  logic [2*SIZE_W-1:0] cells;
  logic [COUNT_W-1:0] total;
  logic               cfg_wr, cell_acc, last_col, last_row, out_free;
  logic               slot_valid;
  node_t              slot_a, slot_b;
  logic [COUNT_W-1:0] down_b;
  inner_join_t        ij;
  uf_req_t            req;
  uf_rsp_t            rsp;

  // Clamp the size registers: zero acts as one, above the maximum acts as it.
  always_comb begin
    rows_eff = rows_cfg_q;
    if (rows_cfg_q == '0) rows_eff = SIZE_W'(1);
    else if (rows_cfg_q > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
    cols_eff = cols_cfg_q;
    if (cols_cfg_q == '0) cols_eff = SIZE_W'(1);
    else if (cols_cfg_q > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
  end

  assign cells    = (2*SIZE_W)'(rows_eff) * (2*SIZE_W)'(cols_eff);
  assign total    = COUNT_W'({cells, 2'b00});
  assign last_col = (SIZE_W'(col_q) + 1'b1) >= cols_eff;
  assign last_row = (SIZE_W'(row_q) + 1'b1) >= rows_eff;
  assign down_b   = COUNT_W'(base_q) + COUNT_W'({cols_eff, 2'b00});

  assign cfg_ready_o = 1'b1;
  assign cfg_wr   = cfg_valid_i && (cfg_index_i == CFG_GRID_ROWS ||
                                    cfg_index_i == CFG_GRID_COLS);
  assign cell_char_stall_o = !(state_q == T_IDLE && !rsp.busy);
  assign cell_acc = cell_char_valid_i && !cell_char_stall_o;
  assign out_free = !out_valid_q || !region_count_stall_i;

  // Pick the node pair for the current join slot.
  always_comb begin
    ij         = inner_join(cls_q, slot_q);
    slot_valid = ij.valid;
    slot_a     = base_q | node_t'(ij.a_off);
    slot_b     = base_q | node_t'(ij.b_off);
    if (slot_q == SLOT_RIGHT) begin
      slot_valid = !last_col;
      slot_a     = base_q | node_t'(1);
      slot_b     = base_q + node_t'(7);
    end else if (slot_q == SLOT_DOWN) begin
      slot_valid = !last_row;
      slot_a     = base_q | node_t'(2);
      slot_b     = node_t'(down_b);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    if (cfg_wr) begin
      state_d = T_IDLE;
    end else begin
      unique case (state_q)
        T_IDLE:  if (cell_acc) state_d = T_ISSUE;
        T_ISSUE: begin
          if (slot_valid) state_d = T_WAIT;
          else if (slot_q == SLOT_DOWN) state_d = T_NEXT;
        end
        T_WAIT: begin
          if (rsp.done) state_d = (slot_q == SLOT_DOWN) ? T_NEXT : T_ISSUE;
        end
        T_NEXT:  state_d = (last_col && last_row) ? T_FIN : T_IDLE;
        T_FIN:   if (out_free) state_d = T_IDLE;
        default: state_d = T_IDLE;
      endcase
    end
  end

  // Engine requests and counters
  always_comb begin
    req          = '0;
    req.a        = slot_a;
    req.b        = slot_b;
    req.clr_last = node_t'(total - 1'b1);
    merges_d     = merges_q;
    slot_d       = slot_q;
    if (cfg_wr) begin
      req.clear    = 1'b1;
      req.clr_last = node_t'(NODE_COUNT - 1);
      merges_d     = '0;
    end else begin
      unique case (state_q)
        T_IDLE:  slot_d = '0;
        T_ISSUE: begin
          if (slot_valid) req.start = 1'b1;
          else if (slot_q != SLOT_DOWN) slot_d = slot_q + 1'b1;
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (rsp.merged) merges_d = merges_q + 1'b1;
            if (slot_q != SLOT_DOWN) slot_d = slot_q + 1'b1;
          end
        end
        T_FIN: begin
          if (out_free) begin
            req.clear = 1'b1;
            merges_d  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat: drop it once taken, load a new one when the grid closes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (region_count_valid_o && !region_count_stall_i) out_valid_d = 1'b0;
    if (state_q == T_FIN && out_free && !cfg_wr) out_valid_d = 1'b1;
  end

  sgrc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      rows_cfg_q  <= SIZE_W'(1);
      cols_cfg_q  <= SIZE_W'(1);
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      merges_q    <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      merges_q    <= merges_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        // restart the grid
        if (cfg_index_i == CFG_GRID_ROWS) rows_cfg_q <= cfg_data_i;
        else cols_cfg_q <= cfg_data_i;
        row_q  <= '0;
        col_q  <= '0;
        base_q <= '0;
      end else if (state_q == T_NEXT) begin
        // advance to the next cell
        base_q <= base_q + node_t'(4);
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (state_q == T_FIN && out_free) begin
        row_q       <= '0;
        col_q       <= '0;
        base_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_acc) begin
      if (cell_char_i == CH_SLASH) cls_q <= CLS_SLASH;
      else if (cell_char_i == CH_BACKSLASH) cls_q <= CLS_BACK;
      else cls_q <= CLS_OPEN;
    end
    // roots left = nodes minus successful merges
    if (state_q == T_FIN && out_free && !cfg_wr) out_count_q <= total - merges_q;
  end

  assign region_count_valid_o = out_valid_q;
  assign region_count_o       = out_count_q;

endmodule
`default_nettype wire
